FILE: design/tarp_pkg.sv
// Shared types, widths and constants for the three-axis rate PID.
`default_nettype none

package tarp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 24;
  localparam int BOUND_W     = 16;
  localparam int DT_W        = 16;
  localparam int DRIVE_W     = 16;
  localparam int TGT_W       = 19;  // stick * 5 before the divide by 4
  localparam int ERR_W       = 18;
  localparam int ACC_W       = 17;
  localparam int DIFF_W      = 19;
  localparam int MAG_W       = 18;  // unsigned multiplier operand
  localparam int PROD_W      = GAIN_W + MAG_W;
  localparam int BIG_W       = 56;  // kd * |diff| * 15625
  localparam int MDIV_W      = BIG_W - 8;
  localparam int SUM_W       = 31;
  localparam int QUOT_W      = 29;
  localparam int REM_W       = 16;
  localparam int CNT_W       = 5;
  localparam int STEP_X_W    = 27;
  localparam int STEP_BITS   = 14;
  localparam int RECIP_W     = 27;
  localparam int STEP_SHIFT  = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 56;

  localparam logic [PROD_W-1:0]       STEP_BIAS    = PROD_W'(1000000);
  // 2^40 / 15625 rounded up; exact for step operands below 2^26
  localparam logic [RECIP_W-1:0]      STEP_RECIP   = RECIP_W'(70368745);
  localparam logic [CNT_W-1:0]        D_NBITS      = CNT_W'(QUOT_W);
  localparam logic signed [SUM_W-1:0] DRIVE_MAX    = SUM_W'(16384);
  localparam logic signed [SUM_W-1:0] D_SAT        = SUM_W'(1) <<< QUOT_W;

  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RP_P  = 3'd0,
    REG_RP_I  = 3'd1,
    REG_RP_D  = 3'd2,
    REG_YAW_P = 3'd3,
    REG_YAW_I = 3'd4,
    REG_YAW_D = 3'd5,
    REG_BOUND = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  rp_p;
    logic [GAIN_W-1:0]  rp_i;
    logic [GAIN_W-1:0]  rp_d;
    logic [GAIN_W-1:0]  yaw_p;
    logic [GAIN_W-1:0]  yaw_i;
    logic [GAIN_W-1:0]  yaw_d;
    logic [BOUND_W-1:0] bound;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rp_p:  GAIN_W'(32768),
    rp_i:  GAIN_W'(19661),
    rp_d:  GAIN_W'(328),
    yaw_p: GAIN_W'(131072),
    yaw_i: GAIN_W'(32768),
    yaw_d: GAIN_W'(655),
    bound: BOUND_W'(1024)
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_MUL_STEP,
    OP_DIV_STEP,
    OP_ACC,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_SCALE1,
    OP_SCALE2,
    OP_DIV_D,
    OP_DSUM,
    OP_DRIVE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic armed;
    logic div_busy;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/three_axis_rate_pid.sv
// Top level: gain registers, controller, datapath and output register.
// Armed item: the three axes pass through the datapath steps in turn, each waiting on the
//   shared divider (29 quotient bits per axis); no new item is taken before the result is emitted.
// Disarmed item: the axis steps are skipped and the result goes to the output register once it is free.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) loads the default gains and clears all loop state.
`default_nettype none

module three_axis_rate_pid import tarp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // armed, stick_roll, stick_pitch, stick_yaw, rate_x, rate_y, rate_z, dt_us
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // roll_drive, pitch_drive, yaw_drive, motors_stopped
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [GAIN_W-1:0]      cfg_data_i
);

  cfg_t                   cfg_q;
  cmd_t                   cmd;
  stat_t                  stat;
  logic                   emit;
  logic                   out_free;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [DRIVE_W-1:0]     roll_drive, pitch_drive, yaw_drive;
  logic                   stopped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RP_P:  cfg_q.rp_p  <= cfg_data_i;
        REG_RP_I:  cfg_q.rp_i  <= cfg_data_i;
        REG_RP_D:  cfg_q.rp_d  <= cfg_data_i;
        REG_YAW_P: cfg_q.yaw_p <= cfg_data_i;
        REG_YAW_I: cfg_q.yaw_i <= cfg_data_i;
        REG_YAW_D: cfg_q.yaw_d <= cfg_data_i;
        REG_BOUND: cfg_q.bound <= cfg_data_i[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  tarp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  tarp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .in_data_i     (s_axis_tdata),
    .stat_o        (stat),
    .roll_drive_o  (roll_drive),
    .pitch_drive_o (pitch_drive),
    .yaw_drive_o   (yaw_drive),
    .stopped_o     (stopped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {{(OUT_TDATA_W-3*DRIVE_W-1){1'b0}}, stopped,
                   yaw_drive, pitch_drive, roll_drive};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

FILE: design/tarp_div.sv
// Restoring divider, one quotient bit per cycle, remainder preloaded.
`default_nettype none

module tarp_div import tarp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [REM_W-1:0]  rem_init_i,
  input  logic [QUOT_W-1:0] low_bits_i,
  input  logic [CNT_W-1:0]  nbits_i,
  input  logic [REM_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q;
  logic [QUOT_W-1:0] low_q;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W-1:0]  div_q;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_q, low_q[QUOT_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign fits      = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_init_i;
      low_q  <= low_bits_i;
      quot_q <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");

  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cnt_q) == CNT_W'(1))
    else $error("divider finished early");

endmodule

`default_nettype wire

FILE: design/tarp_dpath.sv
// Datapath: input latch, per-axis state, shared multiplier and divider.
`default_nettype none

module tarp_dpath import tarp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  cfg_t                  cfg_i,
  input  logic [IN_TDATA_W-1:0] in_data_i,
  output stat_t                 stat_o,
  output logic [DRIVE_W-1:0]    roll_drive_o,
  output logic [DRIVE_W-1:0]    pitch_drive_o,
  output logic [DRIVE_W-1:0]    yaw_drive_o,
  output logic                  stopped_o
);

  // latched item
  logic                       armed_q;
  logic signed [SAMPLE_W-1:0] stick_q [3];
  logic signed [SAMPLE_W-1:0] rate_q  [3];
  logic [DT_W-1:0]            dt_q;

  // per-axis state
  logic signed [ACC_W-1:0]    acc_q   [3];
  logic signed [ERR_W-1:0]    last_q  [3];
  logic [DRIVE_W-1:0]         drive_q [3];
  logic                       stopped_q;

  // working registers
  logic signed [ERR_W-1:0]    err_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic [PROD_W-1:0]          mul_q;
  logic [BIG_W-1:0]           big_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic                       ovf_q;
  logic [STEP_BITS-1:0]       step_q;

  logic                       in_armed;
  logic [DT_W-1:0]            in_dt;

  logic signed [SAMPLE_W-1:0] stick_s, rate_s;
  logic signed [ACC_W-1:0]    acc_s;
  logic signed [ERR_W-1:0]    last_s;
  logic [GAIN_W-1:0]          kp, ki, kd;
  logic                       is_yaw;

  logic signed [TGT_W-1:0]    num_c, adj_c, tgt_c;
  logic signed [ERR_W-1:0]    err_c;
  logic signed [DIFF_W-1:0]   diff_c;

  logic                       err_neg, diff_neg, acc_neg;
  logic [ERR_W-1:0]           err_abs;
  logic [DIFF_W-1:0]          diff_abs;
  logic [ACC_W-1:0]           acc_abs;
  logic [MAG_W-1:0]           err_mag, diff_mag, acc_mag;

  logic [GAIN_W-1:0]          mul_a;
  logic [MAG_W-1:0]           mul_b;
  logic [PROD_W-1:0]          mul_c;

  logic [PROD_W-1:0]          step_sum;
  logic [STEP_X_W-1:0]        step_x;
  logic [STEP_X_W+RECIP_W-1:0] step_prod;
  logic [MDIV_W-1:0]          mdiv;
  logic [MDIV_W-QUOT_W-1:0]   dtop;
  logic [BIG_W-1:0]           scale_in, scale_c;

  logic                       div_start, div_busy;
  logic [REM_W-1:0]           div_rem, div_divisor;
  logic [QUOT_W-1:0]          div_low, div_quot;
  logic [CNT_W-1:0]           div_nbits;

  logic signed [ACC_W:0]      acc_ext, step_s, acc_sum, bnd_s, acc_new;
  logic signed [SUM_W-1:0]    p_term, i_term, d_term, d_mag;
  logic [DRIVE_W-1:0]         drive_c;

  assign in_armed = in_data_i[0];
  assign in_dt    = in_data_i[112:97];

  // axis selection
  always_comb begin
    stick_s = stick_q[2];
    rate_s  = rate_q[2];
    acc_s   = acc_q[2];
    last_s  = last_q[2];
    kp      = cfg_i.yaw_p;
    ki      = cfg_i.yaw_i;
    kd      = cfg_i.yaw_d;
    is_yaw  = 1'b1;
    case (cmd_i.axis)
      AXIS_ROLL, AXIS_PITCH: begin
        stick_s = (cmd_i.axis == AXIS_ROLL) ? stick_q[0] : stick_q[1];
        rate_s  = (cmd_i.axis == AXIS_ROLL) ? rate_q[0]  : rate_q[1];
        acc_s   = (cmd_i.axis == AXIS_ROLL) ? acc_q[0]   : acc_q[1];
        last_s  = (cmd_i.axis == AXIS_ROLL) ? last_q[0]  : last_q[1];
        kp      = cfg_i.rp_p;
        ki      = cfg_i.rp_i;
        kd      = cfg_i.rp_d;
        is_yaw  = 1'b0;
      end
      default: ;
    endcase
  end

  // target (Q.12) = stick / 4 or stick * 5 / 4, truncated toward zero
  always_comb begin
    num_c = {{(TGT_W-SAMPLE_W){stick_s[SAMPLE_W-1]}}, stick_s};
    if (is_yaw) num_c = num_c + (num_c <<< 2);
    adj_c  = num_c + (num_c[TGT_W-1] ? TGT_W'(3) : TGT_W'(0));
    tgt_c  = adj_c >>> 2;
    err_c  = tgt_c[ERR_W-1:0] - {rate_s[SAMPLE_W-1], rate_s, 1'b0};
    diff_c = {err_c[ERR_W-1], err_c} - {last_s[ERR_W-1], last_s};
  end

  assign err_neg  = err_q[ERR_W-1];
  assign diff_neg = diff_q[DIFF_W-1];
  assign acc_neg  = acc_s[ACC_W-1];
  assign err_abs  = err_neg  ? ERR_W'(-err_q)   : ERR_W'(err_q);
  assign diff_abs = diff_neg ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign acc_abs  = acc_neg  ? ACC_W'(-acc_s)   : ACC_W'(acc_s);
  assign err_mag  = err_abs;
  assign diff_mag = diff_abs[MAG_W-1:0];
  assign acc_mag  = {1'b0, acc_abs};

  // shared unsigned multiplier
  always_comb begin
    mul_a = kd;
    mul_b = diff_mag;
    case (cmd_i.op)
      OP_MUL_STEP: begin
        mul_a = {{(GAIN_W-DT_W){1'b0}}, dt_q};
        mul_b = err_mag;
      end
      OP_MUL_P: begin
        mul_a = kp;
        mul_b = err_mag;
      end
      OP_MUL_I: begin
        mul_a = ki;
        mul_b = acc_mag;
      end
      default: ;
    endcase
    mul_c = {{MAG_W{1'b0}}, mul_a} * {{GAIN_W{1'b0}}, mul_b};
  end

  // x * 125 as (x << 7) - (x << 1) - x; applied twice gives x * 15625
  assign scale_in = (cmd_i.op == OP_SCALE1) ? {{(BIG_W-PROD_W){1'b0}}, mul_q} : big_q;
  assign scale_c  = (scale_in << 7) - (scale_in << 1) - scale_in;

  // rounded integral step: (|err| * dt + 10^6) / 2^7 / 15625 by reciprocal
  assign step_sum  = mul_q + STEP_BIAS;
  assign step_x    = step_sum[STEP_X_W+6:7];
  assign step_prod = {{RECIP_W{1'b0}}, step_x} * {{STEP_X_W{1'b0}}, STEP_RECIP};

  // derivative over dt on the serial divider
  assign mdiv        = big_q[BIG_W-1:8];
  assign dtop        = mdiv[MDIV_W-1:QUOT_W];
  assign div_start   = (cmd_i.op == OP_DIV_D);
  assign div_rem     = dtop[REM_W-1:0];
  assign div_low     = mdiv[QUOT_W-1:0];
  assign div_nbits   = D_NBITS;
  assign div_divisor = dt_q;

  tarp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .low_bits_i (div_low),
    .nbits_i    (div_nbits),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // integral update with clamp
  always_comb begin
    acc_ext = {acc_s[ACC_W-1], acc_s};
    step_s  = {{(ACC_W+1-STEP_BITS){1'b0}}, step_q};
    if (err_neg) step_s = -step_s;
    acc_sum = acc_ext + step_s;
    bnd_s   = {2'b00, cfg_i.bound};
    if (acc_sum > bnd_s)       acc_new = bnd_s;
    else if (acc_sum < -bnd_s) acc_new = -bnd_s;
    else                       acc_new = acc_sum;
  end

  // signed P, I, D terms in Q.14
  always_comb begin
    p_term = SUM_W'(mul_q[PROD_W-1:14]);
    if (err_neg) p_term = -p_term;
    i_term = SUM_W'(mul_q[PROD_W-1:13]);
    if (acc_neg) i_term = -i_term;
    d_mag  = ovf_q ? D_SAT : SUM_W'(div_quot);
    d_term = diff_neg ? -d_mag : d_mag;
    if (sum_q > DRIVE_MAX)       drive_c = DRIVE_MAX[DRIVE_W-1:0];
    else if (sum_q < -DRIVE_MAX) drive_c = DRIVE_W'(-DRIVE_MAX);
    else                         drive_c = sum_q[DRIVE_W-1:0];
  end

  // control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      stopped_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        acc_q[a]   <= '0;
        last_q[a]  <= '0;
        drive_q[a] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          armed_q   <= in_armed;
          stopped_q <= !in_armed;
          if (!in_armed) begin
            for (int a = 0; a < 3; a++) begin
              acc_q[a]   <= '0;
              last_q[a]  <= '0;
              drive_q[a] <= '0;
            end
          end
        end
        OP_ERR:   last_q[cmd_i.axis]  <= err_c;
        OP_ACC:   acc_q[cmd_i.axis]   <= acc_new[ACC_W-1:0];
        OP_DRIVE: drive_q[cmd_i.axis] <= drive_c;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        stick_q[0] <= in_data_i[16:1];
        stick_q[1] <= in_data_i[32:17];
        stick_q[2] <= in_data_i[48:33];
        rate_q[0]  <= in_data_i[64:49];
        rate_q[1]  <= in_data_i[80:65];
        rate_q[2]  <= in_data_i[96:81];
        dt_q       <= (in_dt == '0) ? DT_W'(1) : in_dt;
      end
      OP_ERR: begin
        err_q  <= err_c;
        diff_q <= diff_c;
      end
      OP_MUL_STEP, OP_MUL_P: mul_q <= mul_c;
      OP_DIV_STEP: step_q <= step_prod[STEP_SHIFT+STEP_BITS-1:STEP_SHIFT];
      OP_MUL_I: begin
        mul_q <= mul_c;
        sum_q <= p_term;
      end
      OP_MUL_D: begin
        mul_q <= mul_c;
        sum_q <= sum_q + i_term;
      end
      OP_SCALE1, OP_SCALE2: big_q <= scale_c;
      OP_DIV_D: ovf_q <= dtop >= {{(MDIV_W-QUOT_W-DT_W){1'b0}}, dt_q};
      OP_DSUM:  sum_q <= sum_q + d_term;
      default: ;
    endcase
  end

  assign stat_o.armed    = armed_q;
  assign stat_o.div_busy = div_busy;
  assign roll_drive_o    = drive_q[0];
  assign pitch_drive_o   = drive_q[1];
  assign yaw_drive_o     = drive_q[2];
  assign stopped_o       = stopped_q;

endmodule

`default_nettype wire

FILE: design/tarp_ctrl.sv
// Sequencer: walks the three axes through the shared datapath steps when armed.
`default_nettype none

module tarp_ctrl import tarp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  emit_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ERR,
    ST_MSTEP,
    ST_DSTEP,
    ST_ACC,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_SC1,
    ST_SC2,
    ST_DD,
    ST_WD,
    ST_DSUM,
    ST_DRIVE,
    ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          axis_d   = AXIS_ROLL;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: state_d = stat_i.armed ? ST_ERR : ST_FINISH;
      ST_ERR: begin
        cmd_o.op = OP_ERR;
        state_d  = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd_o.op = OP_MUL_STEP;
        state_d  = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd_o.op = OP_DIV_STEP;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_MP;
      end
      ST_MP: begin
        cmd_o.op = OP_MUL_P;
        state_d  = ST_MI;
      end
      ST_MI: begin
        cmd_o.op = OP_MUL_I;
        state_d  = ST_MD;
      end
      ST_MD: begin
        cmd_o.op = OP_MUL_D;
        state_d  = ST_SC1;
      end
      ST_SC1: begin
        cmd_o.op = OP_SCALE1;
        state_d  = ST_SC2;
      end
      ST_SC2: begin
        cmd_o.op = OP_SCALE2;
        state_d  = ST_DD;
      end
      ST_DD: begin
        cmd_o.op = OP_DIV_D;
        state_d  = ST_WD;
      end
      ST_WD: if (!stat_i.div_busy) state_d = ST_DSUM;
      ST_DSUM: begin
        cmd_o.op = OP_DSUM;
        state_d  = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd_o.op = OP_DRIVE;
        if (axis_q == AXIS_YAW) begin
          state_d = ST_FINISH;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_ERR;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AXIS_ROLL;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i) else $error("result written over a pending one");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_DIV_D) |=> stat_i.div_busy)
    else $error("divider did not start");

endmodule

`default_nettype wire
